[sv/gcdist_pkg.sv]
// Shared constants and arithmetic helpers for the great-circle distance core.
// Q2.30 fixed-point trig constants, CORDIC arctangent table, rounded Q30 multiply.
// No dependencies.
package gcdist_pkg;

	localparam int ANGLE_FRAC_BITS   = 16;
	localparam int CORDIC_ITERATIONS = 24;
	localparam int SQRT_STEPS        = 31;

	localparam int RADIUS_W = 23;
	localparam int LAT_W    = 24;
	localparam int LON_W    = 25;
	localparam int DIST_W   = 25;
	localparam int ADDR_W   = 2;

	localparam logic [ADDR_W-1:0]   REG_RADIUS   = 2'd0;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;

	localparam longint Q_ONE           = 64'sd1 << 30;
	localparam longint DEG_TO_RAD_Q30  = 18740330;
	localparam longint CORDIC_INV_GAIN = 652032874;

	// angles in units of 2^-(ANGLE_FRAC_BITS+1) degree
	localparam longint ANG_FULL    = 64'sd360 << (ANGLE_FRAC_BITS + 1);
	localparam longint ANG_HALF    = ANG_FULL / 2;
	localparam longint ANG_QUARTER = ANG_FULL / 4;

	function automatic logic signed [32:0] atan_q30(input int i);
		logic signed [32:0] v;
		case (i)
			0:  v = 33'sd843314857;
			1:  v = 33'sd497837829;
			2:  v = 33'sd263043837;
			3:  v = 33'sd133525159;
			4:  v = 33'sd67021687;
			5:  v = 33'sd33543516;
			6:  v = 33'sd16775851;
			7:  v = 33'sd8388437;
			8:  v = 33'sd4194283;
			9:  v = 33'sd2097149;
			10: v = 33'sd1048576;
			11: v = 33'sd524288;
			12: v = 33'sd262144;
			13: v = 33'sd131072;
			14: v = 33'sd65536;
			15: v = 33'sd32768;
			16: v = 33'sd16384;
			17: v = 33'sd8192;
			18: v = 33'sd4096;
			19: v = 33'sd2048;
			20: v = 33'sd1024;
			21: v = 33'sd512;
			22: v = 33'sd256;
			23: v = 33'sd128;
			24: v = 33'sd64;
			25: v = 33'sd32;
			26: v = 33'sd16;
			27: v = 33'sd8;
			28: v = 33'sd4;
			29: v = 33'sd2;
			30: v = 33'sd1;
			default: v = 33'sd0;
		endcase
		return v;
	endfunction

	// Q30 product, rounded half away from zero
	function automatic logic signed [32:0] mulq(input logic signed [32:0] a,
		input logic signed [32:0] b);
		logic        neg;
		logic [31:0] ua;
		logic [31:0] ub;
		logic [63:0] p;
		logic [32:0] m;
		neg = a[32] ^ b[32];
		ua  = a[32] ? 32'(-a) : 32'(a);
		ub  = b[32] ? 32'(-b) : 32'(b);
		p   = 64'(ua) * 64'(ub) + (64'd1 << 29);
		m   = 33'(p >> 30);
		return neg ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [32:0] clamp1(input logic signed [33:0] v);
		if (v > 34'(Q_ONE))
			return 33'(Q_ONE);
		else if (v < -34'(Q_ONE))
			return -33'(Q_ONE);
		else
			return 33'(v);
	endfunction

endpackage

[sv/great_circle_distance_core.sv]
// Great-circle distance core: haversine with pipelined CORDIC, square roots and atan2.
// Depends on gcdist_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one pair of points per transaction:
//   lat_first, lon_first, lat_second, lon_second in 1/65536 degree, two's complement.
//   Output channel (out_valid / out_stall) returns distance_m in whole metres, one
//   transaction per input, in order.
//   The APB port holds sphere_radius_m at byte address 0; write it only while idle.
// Throughput: one transaction per cycle, the pipeline taking a new pair every cycle
//   while out_stall does not hold a waiting result.
// Pipeline sections in order: angle reduction, sin/cos CORDIC, clamp, products,
//   square roots, atan2 CORDIC, final scale.
// Reset clears all valid bits and loads the radius with 6371000 m.
// When out_stall holds a waiting result, the whole pipeline freezes and in_stall
// rises; nothing is dropped or repeated.
module great_circle_distance_core #(
	parameter int CORDIC_ITERATIONS = gcdist_pkg::CORDIC_ITERATIONS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [gcdist_pkg::LAT_W-1:0]     lat_first,
	input  logic signed [gcdist_pkg::LON_W-1:0]     lon_first,
	input  logic signed [gcdist_pkg::LAT_W-1:0]     lat_second,
	input  logic signed [gcdist_pkg::LON_W-1:0]     lon_second,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic        [gcdist_pkg::DIST_W-1:0]    distance_m,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic        [gcdist_pkg::ADDR_W-1:0]    paddr,
	input  logic        [31:0]                      pwdata,
	output logic        [31:0]                      prdata,
	output logic                                    pready
);
	import gcdist_pkg::*;

	localparam int N = CORDIC_ITERATIONS;

	logic adv;
	logic [RADIUS_W-1:0] radius_q;

	// angle reduction
	logic signed [27:0] ang [0:3];
	logic signed [27:0] wrap [0:3];
	logic signed [27:0] r_s1 [0:3];
	logic v_s1;
	logic [23:0] mag_s2 [0:3];
	logic zneg_s2 [0:3];
	logic cneg_s2 [0:3];
	logic v_s2;
	logic [48:0] prod_s3 [0:3];
	logic zneg_s3 [0:3];
	logic cneg_s3 [0:3];
	logic v_s3;

	// sin/cos rotation
	logic signed [32:0] rx_s [0:N][0:3];
	logic signed [32:0] ry_s [0:N][0:3];
	logic signed [32:0] rz_s [0:N][0:3];
	logic               rneg_s [0:N][0:3];
	logic               rv_s [0:N];

	// clamp and products
	logic signed [32:0] sn_cl_s [0:3];
	logic signed [32:0] cs_cl_s [0:3];
	logic v_cl;
	logic signed [32:0] sp2_p1;
	logic signed [32:0] c12_p1;
	logic signed [32:0] sl2_p1;
	logic v_p1;
	logic signed [32:0] sp2_p2;
	logic signed [32:0] t_p2;
	logic v_p2;
	logic signed [33:0] a_sum;
	logic [30:0] a_cl;

	// square roots: index 0 is the loaded operand, lane 0 = sqrt(a), lane 1 = sqrt(1-a)
	logic [61:0] sq_n_s [0:SQRT_STEPS][0:1];
	logic [61:0] sq_r_s [0:SQRT_STEPS][0:1];
	logic        sq_v_s [0:SQRT_STEPS];

	// atan2 vectoring
	logic signed [33:0] ax_s [0:N];
	logic signed [33:0] ay_s [0:N];
	logic signed [33:0] az_s [0:N];
	logic               av_s [0:N];

	logic signed [34:0] c2z;
	logic [31:0] c_cc;
	logic v_cc;
	logic [54:0] d_md;
	logic v_md;
	logic [DIST_W-1:0] dist_q;
	logic out_valid_q;

	assign adv       = !(out_valid_q && out_stall);
	assign in_stall  = !adv;
	assign out_valid = out_valid_q;
	assign distance_m = dist_q;

	// configuration
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (psel && penable && pwrite && paddr == REG_RADIUS) begin
			radius_q <= pwdata[RADIUS_W-1:0];
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr == REG_RADIUS)
			prdata = 32'(radius_q);
	end

	// all inputs lie within one turn, so one add reduces to (-half, half]
	always_comb begin
		ang[0] = 28'(lat_first) <<< 1;
		ang[1] = 28'(lat_second) <<< 1;
		ang[2] = 28'(lat_second) - 28'(lat_first);
		ang[3] = 28'(lon_second) - 28'(lon_first);
		for (int u = 0; u < 4; u++) begin
			if (ang[u] > 28'(ANG_HALF))
				wrap[u] = ang[u] - 28'(ANG_FULL);
			else if (ang[u] <= -28'(ANG_HALF))
				wrap[u] = ang[u] + 28'(ANG_FULL);
			else
				wrap[u] = ang[u];
		end
	end

	always_comb begin
		a_sum = 34'(sp2_p2) + 34'(t_p2);
		if (a_sum < 0)
			a_cl = '0;
		else if (a_sum > 34'(Q_ONE))
			a_cl = 31'(Q_ONE);
		else
			a_cl = 31'(a_sum);
		c2z = 35'(az_s[N]) <<< 1;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int s = 0; s <= N; s++) begin
				rv_s[s] <= 1'b0;
				av_s[s] <= 1'b0;
			end
			v_cl <= 1'b0;
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			for (int k = 0; k <= SQRT_STEPS; k++)
				sq_v_s[k] <= 1'b0;
			v_cc <= 1'b0;
			v_md <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			rv_s[0] <= v_s3;
			for (int s = 1; s <= N; s++)
				rv_s[s] <= rv_s[s-1];
			v_cl <= rv_s[N];
			v_p1 <= v_cl;
			v_p2 <= v_p1;
			sq_v_s[0] <= v_p2;
			for (int k = 1; k <= SQRT_STEPS; k++)
				sq_v_s[k] <= sq_v_s[k-1];
			av_s[0] <= sq_v_s[SQRT_STEPS];
			for (int s = 1; s <= N; s++)
				av_s[s] <= av_s[s-1];
			v_cc <= av_s[N];
			v_md <= v_cc;
			out_valid_q <= v_md;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int u = 0; u < 4; u++) begin
				r_s1[u] <= wrap[u];

				// fold into [-90, 90]; cosine changes sign
				if (r_s1[u] > 28'(ANG_QUARTER)) begin
					mag_s2[u]  <= 24'(28'(ANG_HALF) - r_s1[u]);
					zneg_s2[u] <= 1'b0;
					cneg_s2[u] <= 1'b1;
				end else if (r_s1[u] < -28'(ANG_QUARTER)) begin
					mag_s2[u]  <= 24'(r_s1[u] + 28'(ANG_HALF));
					zneg_s2[u] <= 1'b1;
					cneg_s2[u] <= 1'b1;
				end else begin
					mag_s2[u]  <= r_s1[u][27] ? 24'(-r_s1[u]) : 24'(r_s1[u]);
					zneg_s2[u] <= r_s1[u][27];
					cneg_s2[u] <= 1'b0;
				end

				prod_s3[u] <= 49'(mag_s2[u]) * 49'(DEG_TO_RAD_Q30)
					+ (49'd1 << ANGLE_FRAC_BITS);
				zneg_s3[u] <= zneg_s2[u];
				cneg_s3[u] <= cneg_s2[u];

				rx_s[0][u]   <= 33'(CORDIC_INV_GAIN);
				ry_s[0][u]   <= '0;
				rz_s[0][u]   <= zneg_s3[u] ? -$signed(33'(prod_s3[u] >> (ANGLE_FRAC_BITS + 1)))
				                            : $signed(33'(prod_s3[u] >> (ANGLE_FRAC_BITS + 1)));
				rneg_s[0][u] <= cneg_s3[u];

				for (int s = 1; s <= N; s++) begin
					if (rz_s[s-1][u] >= 0) begin
						rx_s[s][u] <= rx_s[s-1][u] - (ry_s[s-1][u] >>> (s - 1));
						ry_s[s][u] <= ry_s[s-1][u] + (rx_s[s-1][u] >>> (s - 1));
						rz_s[s][u] <= rz_s[s-1][u] - atan_q30(s - 1);
					end else begin
						rx_s[s][u] <= rx_s[s-1][u] + (ry_s[s-1][u] >>> (s - 1));
						ry_s[s][u] <= ry_s[s-1][u] - (rx_s[s-1][u] >>> (s - 1));
						rz_s[s][u] <= rz_s[s-1][u] + atan_q30(s - 1);
					end
					rneg_s[s][u] <= rneg_s[s-1][u];
				end

				sn_cl_s[u] <= clamp1(34'(ry_s[N][u]));
				cs_cl_s[u] <= clamp1(rneg_s[N][u] ? -34'(rx_s[N][u]) : 34'(rx_s[N][u]));
			end

			// unit 0: lat1, unit 1: lat2, unit 2: dlat, unit 3: dlon
			sp2_p1 <= mulq(sn_cl_s[2], sn_cl_s[2]);
			c12_p1 <= mulq(cs_cl_s[0], cs_cl_s[1]);
			sl2_p1 <= mulq(sn_cl_s[3], sn_cl_s[3]);
			sp2_p2 <= sp2_p1;
			t_p2   <= mulq(c12_p1, sl2_p1);

			sq_n_s[0][0] <= 62'(a_cl) << 30;
			sq_n_s[0][1] <= 62'(31'(Q_ONE) - a_cl) << 30;
			sq_r_s[0][0] <= '0;
			sq_r_s[0][1] <= '0;
			for (int k = 1; k <= SQRT_STEPS; k++) begin
				for (int l = 0; l < 2; l++) begin
					if (sq_n_s[k-1][l] >= sq_r_s[k-1][l] + (62'd1 << (62 - 2 * k))) begin
						sq_n_s[k][l] <= sq_n_s[k-1][l] - sq_r_s[k-1][l]
							- (62'd1 << (62 - 2 * k));
						sq_r_s[k][l] <= (sq_r_s[k-1][l] >> 1) + (62'd1 << (62 - 2 * k));
					end else begin
						sq_n_s[k][l] <= sq_n_s[k-1][l];
						sq_r_s[k][l] <= sq_r_s[k-1][l] >> 1;
					end
				end
			end

			ax_s[0] <= $signed(34'(sq_r_s[SQRT_STEPS][1][30:0]));
			ay_s[0] <= $signed(34'(sq_r_s[SQRT_STEPS][0][30:0]));
			az_s[0] <= '0;
			for (int s = 1; s <= N; s++) begin
				if (ay_s[s-1] > 0) begin
					ax_s[s] <= ax_s[s-1] + (ay_s[s-1] >>> (s - 1));
					ay_s[s] <= ay_s[s-1] - (ax_s[s-1] >>> (s - 1));
					az_s[s] <= az_s[s-1] + 34'(atan_q30(s - 1));
				end else begin
					ax_s[s] <= ax_s[s-1] - (ay_s[s-1] >>> (s - 1));
					ay_s[s] <= ay_s[s-1] + (ax_s[s-1] >>> (s - 1));
					az_s[s] <= az_s[s-1] - 34'(atan_q30(s - 1));
				end
			end

			c_cc   <= c2z[34] ? '0 : 32'(c2z);
			d_md   <= 55'(radius_q) * 55'(c_cc) + (55'd1 << 29);
			dist_q <= d_md[30 +: DIST_W];
		end
	end

endmodule
